[sv/slc_pkg.sv]
`default_nettype none
package slc_pkg;

  localparam int NKW = 10;
  localparam int QDEPTH = 4;

  typedef enum logic [3:0] {
    CLS_HELLO       = 4'd0,
    CLS_MAIL_FROM   = 4'd1,
    CLS_RCPT_TO     = 4'd2,
    CLS_STARTTLS    = 4'd3,
    CLS_DATA        = 4'd4,
    CLS_QUIT        = 4'd5,
    CLS_AUTH        = 4'd6,
    CLS_SECRET      = 4'd7,
    CLS_OTHER       = 4'd8,
    CLS_CODED_REPLY = 4'd9,
    CLS_CONTINUE    = 4'd10,
    CLS_PLAIN_REPLY = 4'd11
  } line_class_t;

  typedef enum logic [1:0] {
    CFG_PORT_A = 2'd0,
    CFG_PORT_B = 2'd1,
    CFG_PORT_C = 2'd2
  } cfg_reg_t;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] PRINT_LO = 8'd32;
  localparam logic [7:0] PRINT_HI = 8'd126;

  localparam logic [15:0] PORT_A_RST = 16'd25;
  localparam logic [15:0] PORT_B_RST = 16'd587;
  localparam logic [15:0] PORT_C_RST = 16'd465;

  // keywords, lowercase, leftmost character in the highest used byte
  localparam logic [79:0] KW_STR [NKW] = '{
    80'("ehlo "), 80'("helo "), 80'("mail from:"), 80'("rcpt to:"), 80'("starttls"),
    80'("data"), 80'("quit"), 80'("auth "), 80'("pass "), 80'("login ")
  };
  localparam logic [3:0] KW_LEN [NKW] = '{
    4'd5, 4'd5, 4'd10, 4'd8, 4'd8, 4'd4, 4'd4, 4'd5, 4'd5, 4'd6
  };
  localparam line_class_t KW_CLASS [NKW] = '{
    CLS_HELLO, CLS_HELLO, CLS_MAIL_FROM, CLS_RCPT_TO, CLS_STARTTLS,
    CLS_DATA, CLS_QUIT, CLS_AUTH, CLS_SECRET, CLS_SECRET
  };

  typedef struct packed {
    logic        kind;
    logic        from_server;
    line_class_t cls;
    logic [9:0]  code;
    logic [7:0]  sep;
    logic [10:0] start;
    logic [11:0] length;
    logic        accepted;
    logic        last;
  } slc_rec_t;

  function automatic logic [7:0] kw_char(input int k, input logic [3:0] p);
    logic [79:0] s;
    int          sh;
    s  = KW_STR[k];
    sh = (int'(KW_LEN[k]) - 1 - int'(p)) * 8;
    if (p < KW_LEN[k]) begin
      kw_char = 8'(s >> sh);
    end else begin
      kw_char = 8'h00;
    end
  endfunction

  // first live keyword that the line is long enough for
  function automatic line_class_t kw_pick(input logic [NKW-1:0] alive,
                                          input logic [3:0] pos4,
                                          input logic pos_hi);
    line_class_t c;
    c = CLS_OTHER;
    for (int k = NKW - 1; k >= 0; k--) begin
      if (alive[k] && (pos_hi || pos4 >= KW_LEN[k])) begin
        c = KW_CLASS[k];
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[sv/slc_kw_match.sv]
`default_nettype none
module slc_kw_match (
  input  wire logic [7:0]             lc_byte,
  input  wire logic [3:0]             pos4,
  input  wire logic                   pos_hi,
  input  wire logic [slc_pkg::NKW-1:0] alive_in,
  output logic      [slc_pkg::NKW-1:0] alive_out
);
  import slc_pkg::*;

  // a keyword dies on the first mismatching byte inside its length
  always_comb begin
    for (int k = 0; k < NKW; k++) begin
      alive_out[k] = alive_in[k] &
                     ~(!pos_hi && (pos4 < KW_LEN[k]) && (lc_byte != kw_char(k, pos4)));
    end
  end

endmodule
`default_nettype wire

[sv/slc_out_queue.sv]
`default_nettype none
module slc_out_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [1:0]       wr_cnt,
  input  wire slc_pkg::slc_rec_t wr_rec0,
  input  wire slc_pkg::slc_rec_t wr_rec1,
  input  wire logic             rd,
  output slc_pkg::slc_rec_t     rd_rec,
  output logic                  rd_valid,
  output logic                  room2
);
  import slc_pkg::*;

  localparam int AW = $clog2(QDEPTH);

  slc_rec_t       q_r [QDEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;
  logic           pop;

  assign rd_valid = (cnt_r != '0);
  assign pop      = rd && rd_valid;
  assign rd_rec   = q_r[rp_r];
  assign room2    = (cnt_r <= (AW+1)'(QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) begin
      q_r[wp_r] <= wr_rec0;
    end
    if (wr_cnt == 2'd2) begin
      q_r[wp_r + AW'(1)] <= wr_rec1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + AW'(wr_cnt);
      rp_r  <= rp_r + AW'(pop);
      cnt_r <= cnt_r + (AW+1)'(wr_cnt) - (AW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

[sv/smtp_line_classifier.sv]
`default_nettype none
// Channel | Dir | Handshake            | Beat
// in_     | in  | in_valid/in_ready    | one payload byte plus packet ports and flags
// out_    | out | out_valid/out_ready  | one line record or one packet verdict
// cfg_    | in  | cfg_we               | write of one mail port register
//
// One byte is taken per cycle while in_ready is high. A byte yields up to two beats
// (line record, verdict); they enter a four-entry result queue in the accept cycle and
// leave one per cycle while out_ready is high. in_ready drops while the queue holds
// more than two beats, so a stalled output side backs up into the input.
// First result is visible in the cycle after the byte is accepted.
// Reset is synchronous: mail ports return to 25/587/465, per-packet state clears.
module smtp_line_classifier #(
  parameter int MAX_PAYLOAD = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic [15:0] in_source_port,
  input  wire logic [15:0] in_dest_port,
  input  wire logic        in_first_of_packet,
  input  wire logic        in_last_of_packet,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_record_kind,
  output logic             out_from_server,
  output logic [3:0]       out_line_class,
  output logic [9:0]       out_reply_code,
  output logic [7:0]       out_separator_byte,
  output logic [10:0]      out_line_start,
  output logic [11:0]      out_line_length,
  output logic             out_packet_accepted,
  output logic             out_is_last,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  import slc_pkg::*;

  // offset and line position must be able to hold MAX_PAYLOAD itself
  localparam int OFFW = $clog2(MAX_PAYLOAD + 1);

  // config
  logic [15:0] port_a_r, port_b_r, port_c_r;

  // packet / line state
  logic [9:0]      ml_r,    ml_nxt;
  logic [OFFW-1:0] off_r,   off_nxt;
  logic [10:0]     lbeg_r,  lbeg_nxt;
  logic [OFFW-1:0] lpos_r,  lpos_nxt;
  logic [NKW-1:0]  alive_r, alive_nxt;
  logic [9:0]      code_r,  code_nxt;
  logic            dok_r,   dok_nxt;
  logic [7:0]      sep_r,   sep_nxt;
  logic            prok_r,  prok_nxt;
  logic            portok_r, portok_nxt;
  logic            srv_r,   srv_nxt;

  logic            accept;
  logic            src_hit, dst_hit;
  logic            port_ok, srv;
  logic [9:0]      ml_cur;
  logic [OFFW-1:0] off_cur, lpos_cur, lpos_upd;
  logic [10:0]     lbeg_cur, lbeg_upd;
  logic [NKW-1:0]  alive_cur, alive_upd, alive_kw;
  logic [9:0]      code_cur, code_upd;
  logic            dok_cur, dok_upd;
  logic [7:0]      sep_cur, sep_upd;
  logic            prok_cur;
  logic            in_limit, is_eol, is_digit, printable, take_byte, close_line;
  logic            line_emit;
  logic [7:0]      lc_byte;
  logic [3:0]      pos4;
  logic            pos_hi;
  line_class_t     cls;
  logic [9:0]      rec_code;
  logic [7:0]      rec_sep;
  logic            coded;
  slc_rec_t        line_rec, verdict_rec, wr0, wr1, head;
  logic [1:0]      wr_cnt;
  logic            room2;

  assign accept = in_valid && in_ready;
  assign in_ready = room2;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_a_r <= PORT_A_RST;
      port_b_r <= PORT_B_RST;
      port_c_r <= PORT_C_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PORT_A: port_a_r <= cfg_wdata;
        CFG_PORT_B: port_b_r <= cfg_wdata;
        CFG_PORT_C: port_c_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign src_hit = (in_source_port == port_a_r) || (in_source_port == port_b_r) ||
                   (in_source_port == port_c_r);
  assign dst_hit = (in_dest_port == port_a_r) || (in_dest_port == port_b_r) ||
                   (in_dest_port == port_c_r);

  // a first-of-packet beat clears per-packet state before the byte is applied
  always_comb begin
    port_ok   = in_first_of_packet ? (src_hit || dst_hit) : portok_r;
    srv       = in_first_of_packet ? src_hit : srv_r;
    ml_cur    = in_first_of_packet ? '0 : ml_r;
    off_cur   = in_first_of_packet ? '0 : off_r;
    lbeg_cur  = in_first_of_packet ? '0 : lbeg_r;
    lpos_cur  = in_first_of_packet ? '0 : lpos_r;
    alive_cur = in_first_of_packet ? '1 : alive_r;
    code_cur  = in_first_of_packet ? '0 : code_r;
    dok_cur   = in_first_of_packet ? 1'b1 : dok_r;
    sep_cur   = in_first_of_packet ? '0 : sep_r;
    prok_cur  = in_first_of_packet ? 1'b1 : prok_r;
  end

  assign is_eol    = (in_data_byte == CH_CR) || (in_data_byte == CH_LF);
  assign is_digit  = (in_data_byte >= CH_ZERO) && (in_data_byte <= CH_NINE);
  assign printable = ((in_data_byte >= PRINT_LO) && (in_data_byte <= PRINT_HI)) || is_eol;
  assign in_limit  = (off_cur < OFFW'(MAX_PAYLOAD));
  assign take_byte = in_limit && !is_eol;
  assign lc_byte   = ((in_data_byte >= "A") && (in_data_byte <= "Z")) ?
                     (in_data_byte + 8'd32) : in_data_byte;
  assign pos4      = lpos_cur[3:0];
  assign pos_hi    = |lpos_cur[OFFW-1:4];

  slc_kw_match u_kw (
    .lc_byte  (lc_byte),
    .pos4     (pos4),
    .pos_hi   (pos_hi),
    .alive_in (alive_cur),
    .alive_out(alive_kw)
  );

  // line state with this byte appended (unchanged for terminators and past the limit)
  always_comb begin
    lpos_upd  = lpos_cur;
    lbeg_upd  = lbeg_cur;
    alive_upd = alive_cur;
    code_upd  = code_cur;
    dok_upd   = dok_cur;
    sep_upd   = sep_cur;
    if (take_byte) begin
      lpos_upd  = lpos_cur + OFFW'(1);
      alive_upd = alive_kw;
      if (lpos_cur == '0) begin
        lbeg_upd = 11'(off_cur);
      end
      if (!pos_hi && pos4 < 4'd3) begin
        if (is_digit) begin
          code_upd = 10'(code_cur * 10'd10 + 10'(in_data_byte - CH_ZERO));
        end else begin
          dok_upd = 1'b0;
        end
      end else if (!pos_hi && pos4 == 4'd3) begin
        sep_upd = in_data_byte;
      end
    end
  end

  // a line closes on a terminator inside the limit, or at end of packet
  assign close_line = (in_limit && is_eol) || in_last_of_packet;
  assign line_emit  = close_line && (lpos_upd != '0) && port_ok;
  assign coded      = srv && dok_upd && (lpos_upd >= OFFW'(3));

  always_comb begin
    rec_code = '0;
    rec_sep  = '0;
    if (srv) begin
      if (coded) begin
        cls      = CLS_CODED_REPLY;
        rec_code = code_upd;
        rec_sep  = sep_upd;
      end else if (ml_cur != '0) begin
        cls      = CLS_CONTINUE;
        rec_code = ml_cur;
      end else begin
        cls = CLS_PLAIN_REPLY;
      end
    end else begin
      cls = kw_pick(alive_upd, lpos_upd[3:0], |lpos_upd[OFFW-1:4]);
    end
  end

  always_comb begin
    line_rec             = '0;
    line_rec.kind        = 1'b0;
    line_rec.from_server = srv;
    line_rec.cls         = cls;
    line_rec.code        = rec_code;
    line_rec.sep         = rec_sep;
    line_rec.start       = lbeg_upd;
    line_rec.length      = 12'(lpos_upd);

    verdict_rec             = '0;
    verdict_rec.kind        = 1'b1;
    verdict_rec.from_server = srv;
    verdict_rec.cls         = CLS_HELLO;
    verdict_rec.accepted    = port_ok && prok_cur && printable;
    verdict_rec.last        = 1'b1;

    wr0    = line_emit ? line_rec : verdict_rec;
    wr1    = verdict_rec;
    wr_cnt = accept ? (2'(line_emit) + 2'(in_last_of_packet)) : 2'd0;
  end

  // next state
  always_comb begin
    portok_nxt = port_ok;
    srv_nxt    = srv;
    prok_nxt   = prok_cur && printable;
    off_nxt    = in_limit ? (off_cur + OFFW'(1)) : off_cur;
    lbeg_nxt   = lbeg_upd;
    ml_nxt     = ml_cur;
    if (line_emit && coded) begin
      ml_nxt = (sep_upd == CH_DASH) ? code_upd : '0;
    end
    if (close_line) begin
      lpos_nxt  = '0;
      alive_nxt = '1;
      code_nxt  = '0;
      dok_nxt   = 1'b1;
      sep_nxt   = '0;
    end else begin
      lpos_nxt  = lpos_upd;
      alive_nxt = alive_upd;
      code_nxt  = code_upd;
      dok_nxt   = dok_upd;
      sep_nxt   = sep_upd;
    end
    if (in_last_of_packet) begin
      ml_nxt   = '0;
      off_nxt  = '0;
      lbeg_nxt = '0;
      prok_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ml_r     <= '0;
      off_r    <= '0;
      lbeg_r   <= '0;
      lpos_r   <= '0;
      alive_r  <= '1;
      code_r   <= '0;
      dok_r    <= 1'b1;
      sep_r    <= '0;
      prok_r   <= 1'b1;
      portok_r <= 1'b0;
      srv_r    <= 1'b0;
    end else if (accept) begin
      ml_r     <= ml_nxt;
      off_r    <= off_nxt;
      lbeg_r   <= lbeg_nxt;
      lpos_r   <= lpos_nxt;
      alive_r  <= alive_nxt;
      code_r   <= code_nxt;
      dok_r    <= dok_nxt;
      sep_r    <= sep_nxt;
      prok_r   <= prok_nxt;
      portok_r <= portok_nxt;
      srv_r    <= srv_nxt;
    end
  end

  slc_out_queue u_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_cnt  (wr_cnt),
    .wr_rec0 (wr0),
    .wr_rec1 (wr1),
    .rd      (out_ready),
    .rd_rec  (head),
    .rd_valid(out_valid),
    .room2   (room2)
  );

  assign out_record_kind     = head.kind;
  assign out_from_server     = head.from_server;
  assign out_line_class      = head.cls;
  assign out_reply_code      = head.code;
  assign out_separator_byte  = head.sep;
  assign out_line_start      = head.start;
  assign out_line_length     = head.length;
  assign out_packet_accepted = head.accepted;
  assign out_is_last         = head.last;

endmodule
`default_nettype wire

[sv/slc_checker.sv]
`default_nettype none
module slc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_record_kind,
  input wire logic [3:0]  out_line_class,
  input wire logic [9:0]  out_reply_code,
  input wire logic [11:0] out_line_length,
  input wire logic        out_packet_accepted,
  input wire logic        out_is_last
);
  import slc_pkg::*;

  // verdict and end-of-packet mark travel together
  a_last_is_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_last == out_record_kind))
    else $error("is_last does not match record kind");

  // line records are never empty and carry no verdict
  a_line_rec: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_record_kind) |->
      (out_line_length != 12'd0) && !out_packet_accepted)
    else $error("bad line record");

  // only coded replies and continuations carry a code
  a_code_class: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_reply_code != 10'd0) |->
      (out_line_class == CLS_CODED_REPLY || out_line_class == CLS_CONTINUE))
    else $error("reply code on wrong class");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_record_kind) &&
      $stable(out_line_length)))
    else $error("stalled result beat changed");

  // input back-pressure only while results are queued
  a_full_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_ready) |-> out_valid)
    else $error("input stalled with empty result queue");

endmodule

bind smtp_line_classifier slc_checker u_slc_checker (.*);
`default_nettype wire
